[hw/rtl/mrm_pkg.sv]
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and the CRC-16 byte update for the Modbus RTU read master.
// ----------------------------------------------------------------------------
package mrm_pkg;

    // input item kinds (carried on s_axis_tuser)
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // result item kinds (carried on m_axis_tuser)
    localparam logic KIND_REQ    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // report status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TIMEOUT     = 3'd1;
    localparam logic [2:0] ST_BAD_SLAVE   = 3'd2;
    localparam logic [2:0] ST_EXCEPTION   = 3'd3;
    localparam logic [2:0] ST_BAD_FUNC    = 3'd4;
    localparam logic [2:0] ST_BAD_COUNT   = 3'd5;
    localparam logic [2:0] ST_CRC_ERROR   = 3'd6;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // supported function codes: 1..4, codes up to 2 read bits
    localparam logic [7:0] FC_MIN      = 8'd1;
    localparam logic [7:0] FC_MAX      = 8'd4;
    localparam logic [7:0] FC_LAST_BIT = 8'd2;

    // reply frame lengths and byte counts
    localparam logic [2:0] LEN_BIT = 3'd6;
    localparam logic [2:0] LEN_REG = 3'd7;
    localparam logic [7:0] CNT_BIT = 8'd1;
    localparam logic [7:0] CNT_REG = 8'd2;

    // quantity field of the request, always one item
    localparam logic [7:0] QTY_HI = 8'h00;
    localparam logic [7:0] QTY_LO = 8'h01;

    localparam int REQ_BYTES   = 8;
    localparam int FRAME_STORE = 6;

    typedef struct packed {
        logic                     req_valid;
        logic [REQ_BYTES*8-1:0]   req_data;   // byte 0 in the lowest bits
        logic                     rpt_valid;
        logic [2:0]               status;
        logic [7:0]               exc_code;
        logic [15:0]              value;
    } emit_load_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/mrm_emit.sv]
// ----------------------------------------------------------------------------
// mrm_emit
// Result register and serialiser: plays out up to eight request bytes and
// one report, one result per cycle on the master stream while m_axis_tready is high.
// ----------------------------------------------------------------------------
module mrm_emit
    import mrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  emit_load_t  load_data,
    output logic        load_free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tx_byte[7:0], status[10:8], exception_code[18:11],
                                        // read_value[34:19], zero[39:35]
    output logic [0:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    logic [3:0]             rem_reg;
    logic                   rpt_pend_reg;
    logic [REQ_BYTES*8-1:0] req_reg;
    logic [2:0]             status_reg;
    logic [7:0]             exc_reg;
    logic [15:0]            value_reg;
    logic                   out_acc;
    logic                   in_req;

    assign in_req        = (rem_reg != 4'd0);
    assign m_axis_tvalid = in_req || rpt_pend_reg;
    assign m_axis_tlast  = in_req ? ((rem_reg == 4'd1) && !rpt_pend_reg) : 1'b1;
    assign m_axis_tuser  = in_req ? KIND_REQ : KIND_REPORT;
    assign m_axis_tdata  = in_req ? {32'd0, req_reg[7:0]}
                                  : {5'd0, value_reg, exc_reg, status_reg, 8'd0};
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign load_free = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= 4'd0;
            rpt_pend_reg <= 1'b0;
        end else if (load) begin
            rem_reg      <= load_data.req_valid ? 4'(REQ_BYTES) : 4'd0;
            rpt_pend_reg <= load_data.rpt_valid;
        end else if (out_acc) begin
            if (in_req) begin
                rem_reg <= rem_reg - 4'd1;
            end else begin
                rpt_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            req_reg    <= load_data.req_data;
            status_reg <= load_data.status;
            exc_reg    <= load_data.exc_code;
            value_reg  <= load_data.value;
        end else if (out_acc && in_req) begin
            req_reg <= {8'd0, req_reg[REQ_BYTES*8-1:8]};
        end
    end

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= 4'(REQ_BYTES))
        else $error("request byte count out of range");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> load_free)
        else $error("result register loaded while still draining");

    a_load_report: assert property (@(posedge aclk) disable iff (!aresetn)
        load && load_data.rpt_valid |=> rpt_pend_reg)
        else $error("report lost on load");

endmodule

[hw/rtl/modbus_rtu_read_master.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_read_master
// Modbus RTU master for single-item reads (function codes 1 to 4).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser selects start request, received line byte or
//   timer tick. A start emits the eight request bytes (CRC low byte first) on
//   m_axis with tuser = 0; a supported code then collects a 6 or 7 byte reply,
//   an unsupported one is followed at once by an unsupported report.
//   Reports (tuser = 1) carry status, exception code and read value, and end
//   a transaction; tlast marks the final result caused by one input item.
//   Bytes and ticks that arrive while no transaction is open are dropped.
//   cfg_we/cfg_wdata set the timeout in ticks; write it only while idle.
// Timing:
//   an accepted item is registered in the input register, handled from there,
//   and its first result is then loaded into the output register.
//   Bytes and ticks are taken one per cycle while no item waits on a busy
//   output register. A start holds the output register while its request
//   bytes and any report play out, and the next item that produces results
//   waits for that; items without results still pass at one per cycle.
//   When m_axis stalls, the output register holds its result; the next item
//   with a result then stays in the input register and s_axis_tready drops.
// Reset: synchronous, active low; idle, timeout 500 ticks, outputs empty.
// ----------------------------------------------------------------------------
module modbus_rtu_read_master
    import mrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,        // timeout_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,     // slave_id[7:0], func_code[15:8],
                                          // item_address[31:16], rx_byte[39:32]
    input  logic [1:0]  s_axis_tuser,     // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,     // tx_byte[7:0], status[10:8],
                                          // exception_code[18:11], read_value[34:19]
    output logic [0:0]  m_axis_tuser,     // kind
    output logic        m_axis_tlast
);

    // input register
    logic        in_vld_reg;
    logic [1:0]  in_mode_reg;
    logic [7:0]  in_slave_reg;
    logic [7:0]  in_fc_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_rx_reg;

    // transaction state
    logic [15:0] timeout_reg;
    logic        busy_reg, busy_next;
    logic [7:0]  saved_slave_reg, saved_slave_next;
    logic [7:0]  saved_func_reg, saved_func_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [2:0]  rcv_cnt_reg, rcv_cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] tick_cnt_reg, tick_cnt_next;
    logic [7:0]  frame_reg [FRAME_STORE];

    logic        fc_ok;
    logic [7:0]  req_b [6];
    logic [15:0] req_crc;
    logic [2:0]  cnt_inc;
    logic        byte_done;
    logic [7:0]  crc_lo;
    logic [15:0] got_crc;
    logic [2:0]  rpt_status;
    logic [7:0]  rpt_exc;
    logic [15:0] rpt_value;
    logic [16:0] tick_inc;
    logic        tick_to;
    logic        need_emit;
    logic        proc_fire;
    logic        emit_free;
    logic        emit_ld;
    emit_load_t  emit_data;

    assign s_axis_tready = !in_vld_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_mode_reg  <= s_axis_tuser;
            in_slave_reg <= s_axis_tdata[7:0];
            in_fc_reg    <= s_axis_tdata[15:8];
            in_addr_reg  <= s_axis_tdata[31:16];
            in_rx_reg    <= s_axis_tdata[39:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    // request frame; only four bytes vary, so the crc flattens to xor trees
    always_comb begin
        fc_ok    = (in_fc_reg >= FC_MIN) && (in_fc_reg <= FC_MAX);
        req_b[0] = in_slave_reg;
        req_b[1] = in_fc_reg;
        req_b[2] = in_addr_reg[15:8];
        req_b[3] = in_addr_reg[7:0];
        req_b[4] = QTY_HI;
        req_b[5] = QTY_LO;
        req_crc  = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            req_crc = crc_byte(req_crc, req_b[i]);
        end
    end

    // reply frame checks, the final byte comes straight from the input register
    always_comb begin
        cnt_inc   = rcv_cnt_reg + 3'd1;
        byte_done = (cnt_inc == exp_len_reg);
        crc_lo    = (exp_len_reg == LEN_REG) ? frame_reg[5] : frame_reg[4];
        got_crc   = {in_rx_reg, crc_lo};
        rpt_exc   = 8'd0;
        rpt_value = 16'd0;
        if (frame_reg[0] != saved_slave_reg) begin
            rpt_status = ST_BAD_SLAVE;
        end else if (frame_reg[1] == (saved_func_reg | EXC_FLAG)) begin
            rpt_status = ST_EXCEPTION;
            rpt_exc    = frame_reg[2];
        end else if (frame_reg[1] != saved_func_reg) begin
            rpt_status = ST_BAD_FUNC;
        end else if (frame_reg[2] != ((exp_len_reg == LEN_REG) ? CNT_REG : CNT_BIT)) begin
            rpt_status = ST_BAD_COUNT;
        end else if (got_crc != crc_reg) begin
            rpt_status = ST_CRC_ERROR;
        end else begin
            rpt_status = ST_OK;
            rpt_value  = (exp_len_reg == LEN_REG) ? {frame_reg[3], frame_reg[4]}
                                                  : {15'd0, frame_reg[3][0]};
        end
    end

    assign tick_inc = {1'b0, tick_cnt_reg} + 17'd1;
    assign tick_to  = (tick_inc >= {1'b0, timeout_reg});

    always_comb begin
        case (in_mode_reg)
            MODE_START: need_emit = 1'b1;
            MODE_BYTE:  need_emit = busy_reg && byte_done;
            MODE_TICK:  need_emit = busy_reg && tick_to;
            default:    need_emit = 1'b0;
        endcase
    end

    assign proc_fire = in_vld_reg && (!need_emit || emit_free);
    assign emit_ld   = proc_fire && need_emit;

    always_comb begin
        emit_data           = '0;
        emit_data.req_data  = {req_crc[15:8], req_crc[7:0], req_b[5], req_b[4],
                               req_b[3], req_b[2], req_b[1], req_b[0]};
        busy_next           = busy_reg;
        saved_slave_next    = saved_slave_reg;
        saved_func_next     = saved_func_reg;
        exp_len_next        = exp_len_reg;
        rcv_cnt_next        = rcv_cnt_reg;
        crc_next            = crc_reg;
        tick_cnt_next       = tick_cnt_reg;
        case (in_mode_reg)
            MODE_START: begin
                emit_data.req_valid = 1'b1;
                emit_data.rpt_valid = !fc_ok;
                emit_data.status    = ST_UNSUPPORTED;
                saved_slave_next    = in_slave_reg;
                saved_func_next     = in_fc_reg;
                crc_next            = CRC_INIT;
                rcv_cnt_next        = 3'd0;
                tick_cnt_next       = 16'd0;
                busy_next           = fc_ok;
                if (!fc_ok) begin
                    exp_len_next = 3'd0;
                end else begin
                    exp_len_next = (in_fc_reg <= FC_LAST_BIT) ? LEN_BIT : LEN_REG;
                end
            end
            MODE_BYTE: begin
                emit_data.rpt_valid = 1'b1;
                emit_data.status    = rpt_status;
                emit_data.exc_code  = rpt_exc;
                emit_data.value     = rpt_value;
                if (busy_reg) begin
                    if (byte_done) begin
                        crc_next      = CRC_INIT;
                        busy_next     = 1'b0;
                        rcv_cnt_next  = 3'd0;
                        tick_cnt_next = 16'd0;
                    end else begin
                        rcv_cnt_next = cnt_inc;
                        // the two crc bytes of the reply stay out of the sum
                        if (rcv_cnt_reg < (exp_len_reg - 3'd2)) begin
                            crc_next = crc_byte(crc_reg, in_rx_reg);
                        end
                    end
                end
            end
            MODE_TICK: begin
                emit_data.rpt_valid = 1'b1;
                emit_data.status    = ST_TIMEOUT;
                if (busy_reg) begin
                    if (tick_to) begin
                        crc_next      = CRC_INIT;
                        busy_next     = 1'b0;
                        rcv_cnt_next  = 3'd0;
                        tick_cnt_next = 16'd0;
                    end else begin
                        tick_cnt_next = tick_inc[15:0];
                    end
                end
            end
            default: begin
                busy_next = busy_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            saved_slave_reg <= 8'd0;
            saved_func_reg  <= 8'd0;
            exp_len_reg     <= 3'd0;
            rcv_cnt_reg     <= 3'd0;
            crc_reg         <= CRC_INIT;
            tick_cnt_reg    <= 16'd0;
        end else if (proc_fire) begin
            busy_reg        <= busy_next;
            saved_slave_reg <= saved_slave_next;
            saved_func_reg  <= saved_func_next;
            exp_len_reg     <= exp_len_next;
            rcv_cnt_reg     <= rcv_cnt_next;
            crc_reg         <= crc_next;
            tick_cnt_reg    <= tick_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && (in_mode_reg == MODE_BYTE) && busy_reg && !byte_done) begin
            frame_reg[rcv_cnt_reg] <= in_rx_reg;
        end
    end

    mrm_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (emit_ld),
        .load_data     (emit_data),
        .load_free     (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_busy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (exp_len_reg == LEN_BIT) || (exp_len_reg == LEN_REG))
        else $error("open transaction without a valid frame length");

    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rcv_cnt_reg < exp_len_reg))
        else $error("received count ran past the frame length");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (rcv_cnt_reg == 3'd0) && (tick_cnt_reg == 16'd0))
        else $error("counters left set while idle");

    a_emit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_ld |-> emit_free)
        else $error("results handed over while output still busy");

endmodule
